// ===== src/lbh_pkg.sv =====
// Package for the logarithmically binned histogram.
// Holds the word types, register indexes, reset values and the log2 fraction table.
// No dependencies.
package lbh_pkg;

    localparam int NUM_BINS_DEF   = 64;
    localparam int COUNT_BITS_DEF = 32;

    // Configuration port geometry.
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;

    // Register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] REG_LOG2_LOWER_BOUND = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BINS_PER_OCTAVE  = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BINS_USED        = 2'd2;

    // Register reset values.
    localparam logic [14:0] LOWER_BOUND_RST = 15'd0;
    localparam logic [15:0] BPO_RST         = 16'd256;
    localparam logic [6:0]  BINS_USED_RST   = 7'd64;

    // Largest number of results one readout may return.
    localparam int MAX_OUT = 64;

    // Operation codes.
    localparam logic OP_SAMPLE  = 1'b0;
    localparam logic OP_READOUT = 1'b1;

    typedef struct packed {
        logic        op;
        logic [31:0] sample_value;
    } in_word_t;

    typedef struct packed {
        logic [5:0]  bin_number;
        logic [31:0] bin_count;
        logic        last_bin;
    } out_word_t;

    // round(1024 * log2(1 + i/32)) for i = 0..32.
    function automatic logic [10:0] frac_lut(input logic [5:0] i);
        logic [10:0] t;
        case (i)
            6'd0:  t = 11'd0;
            6'd1:  t = 11'd45;
            6'd2:  t = 11'd90;
            6'd3:  t = 11'd132;
            6'd4:  t = 11'd174;
            6'd5:  t = 11'd214;
            6'd6:  t = 11'd254;
            6'd7:  t = 11'd292;
            6'd8:  t = 11'd330;
            6'd9:  t = 11'd366;
            6'd10: t = 11'd402;
            6'd11: t = 11'd436;
            6'd12: t = 11'd470;
            6'd13: t = 11'd504;
            6'd14: t = 11'd536;
            6'd15: t = 11'd568;
            6'd16: t = 11'd599;
            6'd17: t = 11'd629;
            6'd18: t = 11'd659;
            6'd19: t = 11'd689;
            6'd20: t = 11'd717;
            6'd21: t = 11'd745;
            6'd22: t = 11'd773;
            6'd23: t = 11'd800;
            6'd24: t = 11'd827;
            6'd25: t = 11'd853;
            6'd26: t = 11'd879;
            6'd27: t = 11'd904;
            6'd28: t = 11'd929;
            6'd29: t = 11'd953;
            6'd30: t = 11'd977;
            6'd31: t = 11'd1001;
            6'd32: t = 11'd1024;
            default: t = 11'd0;
        endcase
        return t;
    endfunction

endpackage

// ===== src/log_binned_histogram.sv =====
// Logarithmically binned histogram: top level with the log2 pipeline and bin store control.
// Depends on lbh_pkg and lbh_ram.
// Sample words: one accepted per cycle while no readout or clearing pass runs; the bin is
// updated when the sample reaches the write-back stage. Readout word: waits for samples
// in flight, then reads, reports and clears each bin in use (held back while m_ready
// stalls) and clears the remaining bins of the store.
// Reset (aresetn low, synchronous) restores the registers and then runs a clearing pass
// over every bin of the bin store, during which no word is accepted.
module log_binned_histogram #(
    parameter int NUM_BINS   = lbh_pkg::NUM_BINS_DEF,
    parameter int COUNT_BITS = lbh_pkg::COUNT_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Sample and readout words.
    input  logic                               s_valid,
    output logic                               s_ready,
    input  lbh_pkg::in_word_t                  s_data,
    // Result words, one per bin in use on readout.
    output logic                               m_valid,
    input  logic                               m_ready,
    output lbh_pkg::out_word_t                 m_data,
    // Configuration writes.
    input  logic                               cfg_we,
    input  logic [lbh_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [lbh_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);

    localparam int AW = $clog2(NUM_BINS);
    // Wide enough for a bin pointer plus one and for the 7-bit bins_used value.
    localparam int KW = (AW + 1 > 7) ? AW + 1 : 7;
    localparam int USED_MAX = (NUM_BINS < lbh_pkg::MAX_OUT) ? NUM_BINS : lbh_pkg::MAX_OUT;
    localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_BINS - 1);

    // Control states.
    localparam logic [2:0] ST_CLR   = 3'd0;  // writing zeros through the store
    localparam logic [2:0] ST_RUN   = 3'd1;  // taking words
    localparam logic [2:0] ST_DRAIN = 3'd2;  // readout waits for samples in flight
    localparam logic [2:0] ST_RD    = 3'd3;  // read and clear one bin that is reported
    localparam logic [2:0] ST_DATA  = 3'd4;  // load that bin into the output register

    // Configuration registers.
    logic [14:0] lower_bound_reg;
    logic [15:0] bpo_reg;
    logic [6:0]  bins_used_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lower_bound_reg <= lbh_pkg::LOWER_BOUND_RST;
            bpo_reg         <= lbh_pkg::BPO_RST;
            bins_used_reg   <= lbh_pkg::BINS_USED_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                lbh_pkg::REG_LOG2_LOWER_BOUND: lower_bound_reg <= cfg_wdata[14:0];
                lbh_pkg::REG_BINS_PER_OCTAVE:  bpo_reg         <= cfg_wdata;
                lbh_pkg::REG_BINS_USED:        bins_used_reg   <= cfg_wdata[6:0];
                default: ;
            endcase
        end
    end

    // Bins in use, clamped to the store size and to the result limit.
    logic [6:0] eff_used;
    assign eff_used = (bins_used_reg > 7'(USED_MAX)) ? 7'(USED_MAX) : bins_used_reg;

    logic [2:0] state_reg, state_next;
    logic       in_accept;

    assign s_ready   = (state_reg == ST_RUN);
    assign in_accept = s_valid && s_ready;

    // Stage 1 holds the accepted sample. Zero samples and readout words never enter.
    logic        s1_v_reg;
    logic [31:0] s1_val_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_v_reg <= 1'b0;
        end else begin
            s1_v_reg <= in_accept && (s_data.op == lbh_pkg::OP_SAMPLE)
                        && (s_data.sample_value != 32'd0);
        end
        s1_val_reg <= s_data.sample_value;
    end

    // Stage 1 to 2: leading-one position and normalization.
    logic [4:0]  lead_pos;
    logic [31:0] norm_val;

    always_comb begin
        lead_pos = 5'd0;
        for (int i = 0; i < 32; i++) begin
            if (s1_val_reg[i]) begin
                lead_pos = 5'(i);
            end
        end
        norm_val = s1_val_reg << (5'd31 - lead_pos);
    end

    logic       s2_v_reg;
    logic [4:0] s2_exp_reg;
    logic [4:0] s2_idx_reg;
    logic [4:0] s2_rem_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_v_reg <= 1'b0;
        end else begin
            s2_v_reg <= s1_v_reg;
        end
        s2_exp_reg <= lead_pos;
        s2_idx_reg <= norm_val[30:26];
        s2_rem_reg <= norm_val[25:21];
    end

    // Stage 2 to 3: fraction by table and linear interpolation, then offset by the bound.
    logic [10:0] frac_lo, frac_hi, frac_diff;
    logic [15:0] interp_prod;
    logic [14:0] log_val;
    logic        above_bound;

    always_comb begin
        frac_lo     = lbh_pkg::frac_lut({1'b0, s2_idx_reg});
        frac_hi     = lbh_pkg::frac_lut(6'({1'b0, s2_idx_reg}) + 6'd1);
        frac_diff   = frac_hi - frac_lo;
        interp_prod = {5'd0, frac_diff} * {11'd0, s2_rem_reg};
        log_val     = {s2_exp_reg, 10'd0} + {4'd0, frac_lo} + {4'd0, interp_prod[15:5]};
        above_bound = (log_val >= lower_bound_reg);
    end

    logic        s3_v_reg;
    logic [14:0] s3_delta_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_v_reg <= 1'b0;
        end else begin
            s3_v_reg <= s2_v_reg && above_bound;
        end
        s3_delta_reg <= log_val - lower_bound_reg;
    end

    // Stage 3 to 4: scale by bins per octave and floor; drop bins past the range.
    logic [30:0] scale_prod;
    logic [12:0] bin_idx;
    logic        bin_ok;

    assign scale_prod = {16'd0, s3_delta_reg} * {15'd0, bpo_reg};
    assign bin_idx    = scale_prod[30:18];
    assign bin_ok     = (bin_idx < {6'd0, eff_used});

    logic          s4_v_reg;
    logic [AW-1:0] s4_addr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_v_reg <= 1'b0;
        end else begin
            s4_v_reg <= s3_v_reg && bin_ok;
        end
        s4_addr_reg <= AW'(bin_idx);
    end

    // Stage 4 reads the bin; stage 5 increments it and writes it back.
    logic          s5_v_reg;
    logic [AW-1:0] s5_addr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s5_v_reg <= 1'b0;
        end else begin
            s5_v_reg <= s4_v_reg;
        end
        s5_addr_reg <= s4_addr_reg;
    end

    // The RAM read that runs alongside a write to the same bin returns the old count,
    // so the last written count is forwarded from a register to the next increment.
    logic                  fwd_v_reg;
    logic [AW-1:0]         fwd_addr_reg;
    logic [COUNT_BITS-1:0] fwd_data_reg;
    logic [COUNT_BITS-1:0] ram_rdata;
    logic [COUNT_BITS-1:0] cur_count, inc_count;

    assign cur_count = (fwd_v_reg && (fwd_addr_reg == s5_addr_reg)) ? fwd_data_reg : ram_rdata;
    assign inc_count = (&cur_count) ? cur_count : cur_count + COUNT_BITS'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_v_reg <= 1'b0;
        end else begin
            fwd_v_reg <= s5_v_reg;
        end
        fwd_addr_reg <= s5_addr_reg;
        fwd_data_reg <= inc_count;
    end

    logic pipe_empty;
    assign pipe_empty = !(s1_v_reg || s2_v_reg || s3_v_reg || s4_v_reg || s5_v_reg);

    // Sweep pointer, shared by the clearing pass and the readout.
    logic [AW-1:0] k_reg, k_next;
    logic [KW-1:0] k_ext;
    logic [KW-1:0] used_ext;
    logic          is_last_out;

    assign k_ext       = KW'(k_reg);
    assign used_ext    = KW'(eff_used);
    assign is_last_out = ((k_ext + KW'(1)) == used_ext);

    // Output register.
    logic               m_valid_reg, m_valid_next;
    lbh_pkg::out_word_t m_data_reg, m_data_next;
    logic [31:0]        out_count;

    always_comb begin
        if ((COUNT_BITS > 32) && ((ram_rdata >> 32) != '0)) begin
            out_count = 32'hFFFF_FFFF;
        end else begin
            out_count = 32'(ram_rdata);
        end
    end

    logic sweep_we;
    assign sweep_we = ((state_reg == ST_RD) && !m_valid_reg) || (state_reg == ST_CLR);

    always_comb begin
        state_next   = state_reg;
        k_next       = k_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;

        unique case (state_reg)
            ST_CLR: begin
                if (k_reg == LAST_ADDR) begin
                    k_next     = '0;
                    state_next = ST_RUN;
                end else begin
                    k_next = k_reg + AW'(1);
                end
            end
            ST_RUN: begin
                if (in_accept && (s_data.op == lbh_pkg::OP_READOUT)) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (pipe_empty) begin
                    state_next = (eff_used == 7'd0) ? ST_CLR : ST_RD;
                end
            end
            ST_RD: begin
                // Wait for an empty output register so the read data can land.
                if (!m_valid_reg) begin
                    state_next = ST_DATA;
                end
            end
            ST_DATA: begin
                m_valid_next           = 1'b1;
                m_data_next.bin_number = 6'(k_reg);
                m_data_next.bin_count  = out_count;
                m_data_next.last_bin   = is_last_out;
                if (is_last_out) begin
                    if (k_reg == LAST_ADDR) begin
                        k_next     = '0;
                        state_next = ST_RUN;
                    end else begin
                        k_next     = k_reg + AW'(1);
                        state_next = ST_CLR;
                    end
                end else begin
                    k_next     = k_reg + AW'(1);
                    state_next = ST_RD;
                end
            end
            default: begin
                state_next = ST_CLR;
                k_next     = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLR;
            k_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            k_reg       <= k_next;
            m_valid_reg <= m_valid_next;
        end
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Bin store. Sample writes and sweep writes never coincide: the sweep starts
    // only after the sample pipeline has drained.
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr, ram_raddr;
    logic [COUNT_BITS-1:0] ram_wdata;

    assign ram_we    = s5_v_reg || sweep_we;
    assign ram_waddr = s5_v_reg ? s5_addr_reg : k_reg;
    assign ram_wdata = s5_v_reg ? inc_count : '0;
    assign ram_raddr = (state_reg == ST_RD) ? k_reg : s4_addr_reg;

    lbh_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (NUM_BINS)
    ) u_bin_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // A readout sweep never starts while samples are still in flight.
    a_sweep_after_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RD) |-> pipe_empty)
        else $error("readout sweep with samples in flight");

    // Sample write-back happens only while taking words or draining.
    a_write_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        s5_v_reg |-> ((state_reg == ST_RUN) || (state_reg == ST_DRAIN)))
        else $error("sample write-back during sweep");

    // A bin is loaded into the output register only when it is empty.
    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DATA) |-> !m_valid_reg)
        else $error("output register overwritten");

    // A new result word appears only after a readout data cycle.
    a_out_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == ST_DATA))
        else $error("result word without readout");

endmodule

// ===== src/lbh_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// A read of the address being written in the same cycle returns the old data.
// No dependencies.
module lbh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

endmodule
